>>> src/u8250rb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8250rb_pkg: shared types and codes of the 8250 register block
// State and result records, command and register offset codes, helpers.
// ----------------------------------------------------------------------------
package u8250rb_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RECEIVE = 2'd2;

  // register offsets
  localparam logic [2:0] OFS_DATA = 3'd0;
  localparam logic [2:0] OFS_IER  = 3'd1;
  localparam logic [2:0] OFS_IIR  = 3'd2;
  localparam logic [2:0] OFS_LCR  = 3'd3;
  localparam logic [2:0] OFS_MCR  = 3'd4;
  localparam logic [2:0] OFS_LSR  = 3'd5;
  localparam logic [2:0] OFS_MSR  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_MODEM_STATUS = 2'd0;
  localparam logic [1:0] CFG_TX_ATTACHED  = 2'd1;
  localparam logic [1:0] CFG_IRQ_LINE     = 2'd2;

  localparam logic [7:0] CFG_MODEM_STATUS_RST = 8'h30;
  localparam logic [3:0] CFG_IRQ_LINE_RST     = 4'd4;

  // pending flag bits
  localparam int PEND_LSR = 0;
  localparam int PEND_RX  = 1;
  localparam int PEND_TX  = 2;
  localparam int PEND_MSR = 3;

  // interrupt enable bits
  localparam int IEN_RX  = 0;
  localparam int IEN_TX  = 1;
  localparam int IEN_LSR = 2;

  localparam logic [7:0] LSR_BASE     = 8'h60;
  localparam logic [7:0] SCRATCH_READ = 8'hFF;
  localparam logic [7:0] IIR_ID_LSR   = 8'h06;
  localparam logic [7:0] IIR_ID_RX    = 8'h04;
  localparam logic [7:0] IIR_ID_TX    = 8'h02;
  localparam logic [7:0] MSR_UPPER    = 8'hF0;

  typedef struct packed {
    logic        latch_access;
    logic [15:0] divisor_latch;
    logic [7:0]  int_enable;
    logic [7:0]  line_control;
    logic [7:0]  modem_ctrl;
    logic [7:0]  rx_holding;
    logic        rx_ready;
    logic [3:0]  pending_flags;
    logic [7:0]  last_modem_status;
  } uart_state_t;

  typedef struct packed {
    logic [7:0] modem_status;
    logic       tx_attached;
    logic [3:0] irq_line;
  } uart_cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] offset;
    logic [7:0] data;
  } uart_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [3:0] irq_number;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       mcr_strobe;
    logic [7:0] modem_control;
  } uart_result_t;

  // transmit mask from the word length select bits
  function automatic logic [7:0] word_mask(input logic [1:0] wls);
    logic [7:0] m;
    case (wls)
      2'd0:    m = 8'h1F;
      2'd1:    m = 8'h3F;
      2'd2:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> src/u8250rb_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8250rb_step: one register access
// Next state and result of one request, from the current state and config.
// ----------------------------------------------------------------------------
module u8250rb_step
  import u8250rb_pkg::*;
(
  input  wire uart_state_t  state_i,
  input  wire uart_cfg_t    cfg_i,
  input  wire uart_req_t    req_i,
  output uart_state_t       state_o,
  output uart_result_t      res_o
);

  always_comb begin
    logic [7:0] tx_char;
    logic [7:0] rd;
    logic [7:0] msr_diff;
    logic       irq;
    logic       txv;
    logic [7:0] txb;
    logic       strobe;
    logic       rx_take;
    logic [7:0] rx_char;
    uart_state_t s;

    s        = state_i;
    rd       = '0;
    irq      = 1'b0;
    txv      = 1'b0;
    txb      = '0;
    strobe   = 1'b0;
    rx_take  = 1'b0;
    rx_char  = req_i.data;
    tx_char  = req_i.data & word_mask(state_i.line_control[1:0]);
    msr_diff = cfg_i.modem_status ^ state_i.last_modem_status;

    case (req_i.command)
      CMD_WRITE: begin
        case (req_i.offset)
          OFS_DATA: begin
            if (!state_i.latch_access) begin
              if (state_i.modem_ctrl[4]) begin
                // loopback into receive
                rx_take = 1'b1;
                rx_char = tx_char;
              end else if (cfg_i.tx_attached) begin
                txv = 1'b1;
                txb = tx_char;
                if (state_i.int_enable[IEN_TX]) begin
                  s.pending_flags[PEND_TX] = 1'b1;
                  irq = 1'b1;
                end
                if (state_i.int_enable[IEN_LSR]) begin
                  s.pending_flags[PEND_LSR] = 1'b1;
                  irq = 1'b1;
                end
              end
            end else begin
              s.divisor_latch[7:0] = req_i.data;
            end
          end
          OFS_IER: begin
            if (!state_i.latch_access) s.int_enable = req_i.data;
            else s.divisor_latch[15:8] = req_i.data;
          end
          OFS_LCR: begin
            s.line_control = req_i.data;
            s.latch_access = req_i.data[7];
          end
          OFS_MCR: begin
            s.modem_ctrl = req_i.data;
            strobe       = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (req_i.offset)
          OFS_DATA: begin
            if (!state_i.latch_access) begin
              rd         = state_i.rx_holding;
              s.rx_ready = 1'b0;
              s.pending_flags[PEND_RX] = 1'b0;
              if (state_i.int_enable[IEN_LSR]) begin
                s.pending_flags[PEND_LSR] = 1'b1;
                irq = 1'b1;
              end
            end else begin
              rd = state_i.divisor_latch[7:0];
            end
          end
          OFS_IER: begin
            rd = state_i.latch_access ? state_i.divisor_latch[15:8] : state_i.int_enable;
          end
          OFS_IIR: begin
            rd = {7'd0, ~|state_i.pending_flags};
            if (state_i.pending_flags[PEND_LSR]) begin
              rd = rd | IIR_ID_LSR;
            end else if (state_i.pending_flags[PEND_RX]) begin
              rd = rd | IIR_ID_RX;
            end else if (state_i.pending_flags[PEND_TX]) begin
              rd = rd | IIR_ID_TX;
              s.pending_flags[PEND_TX] = 1'b0;
            end
            irq = |s.pending_flags;
          end
          OFS_LCR: rd = state_i.line_control;
          OFS_MCR: rd = state_i.modem_ctrl;
          OFS_LSR: begin
            rd = LSR_BASE | {7'd0, state_i.rx_ready};
            s.pending_flags[PEND_LSR] = 1'b0;
          end
          OFS_MSR: begin
            rd = (cfg_i.modem_status & MSR_UPPER)
               | {4'd0, msr_diff[7], 1'b0, msr_diff[5], msr_diff[4]};
            s.last_modem_status = cfg_i.modem_status;
            s.pending_flags[PEND_MSR] = 1'b0;
          end
          default: rd = SCRATCH_READ;
        endcase
      end
      CMD_RECEIVE: rx_take = 1'b1;
      default: ;
    endcase

    if (rx_take) begin
      s.rx_holding = rx_char;
      s.rx_ready   = 1'b1;
      if (state_i.int_enable[IEN_RX]) begin
        s.pending_flags[PEND_RX] = 1'b1;
        irq = 1'b1;
      end
    end

    state_o = s;
    res_o.read_data     = rd;
    res_o.irq_request   = irq;
    res_o.irq_number    = irq ? cfg_i.irq_line : 4'd0;
    res_o.tx_valid      = txv;
    res_o.tx_byte       = txb;
    res_o.mcr_strobe    = strobe;
    res_o.modem_control = s.modem_ctrl;
  end

endmodule
`default_nettype wire

>>> src/uart_8250_register_block_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_8250_register_block_unit: simplified 8250 uart register file
// Register writes, reads and received bytes in; one result per request out.
// ----------------------------------------------------------------------------
// usage:
//   in_* is a valid/ready channel carrying one request: a register write,
//   a register read or a received byte (command, offset, data).
//   out_* is a valid/ready channel carrying one result per request: read
//   data, interrupt request and line, transmitted byte, modem control.
//   cfg_we/cfg_index/cfg_wdata write the modem status lines, the transmit
//   sink flag and the interrupt line; write them only while the block is idle.
// latency and throughput:
//   a request's result is valid the cycle after acceptance unless out stalls;
//   state update is combinational; one request per cycle while skid is empty.
// stalls:
//   results sit in an output register backed by one skid entry, so a request
//   is still taken while a result waits; in_ready drops only once both hold.
// reset:
//   rst_n (synchronous) clears all uart state to zero, empties the output
//   stages and restores the config registers (status 0x30, line 4, no sink).
// ----------------------------------------------------------------------------
module uart_8250_register_block_unit
  import u8250rb_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  // request channel
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] in_command,
  input  wire  [2:0] in_offset,
  input  wire  [7:0] in_data,
  // result channel
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_request,
  output logic [3:0] out_irq_number,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_mcr_strobe,
  output logic [7:0] out_modem_control,
  // configuration port
  input  wire        cfg_we,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_wdata
);

  uart_state_t  state_r, state_nxt;
  uart_cfg_t    cfg_r;
  uart_req_t    req;
  uart_result_t res_nxt;
  uart_result_t out_r, skid_r;
  logic         out_valid_r, skid_valid_r;
  logic         in_fire;

  assign req.command = in_command;
  assign req.offset  = in_offset;
  assign req.data    = in_data;

  // skid entry full is the only thing that stops requests
  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_valid & in_ready;

  u8250rb_step u_step (
    .state_i (state_r),
    .cfg_i   (cfg_r),
    .req_i   (req),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modem_status <= CFG_MODEM_STATUS_RST;
      cfg_r.tx_attached  <= 1'b0;
      cfg_r.irq_line     <= CFG_IRQ_LINE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODEM_STATUS: cfg_r.modem_status <= cfg_wdata;
        CFG_TX_ATTACHED:  cfg_r.tx_attached  <= cfg_wdata[0];
        CFG_IRQ_LINE:     cfg_r.irq_line     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // uart state, updated once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_ready || !out_valid_r) begin
        if (skid_valid_r) begin
          // drain skid first, no request taken this cycle
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        // output stalled, park the new result
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_fire) out_r <= res_nxt;
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_r.read_data;
  assign out_irq_request   = out_r.irq_request;
  assign out_irq_number    = out_r.irq_number;
  assign out_tx_valid      = out_r.tx_valid;
  assign out_tx_byte       = out_r.tx_byte;
  assign out_mcr_strobe    = out_r.mcr_strobe;
  assign out_modem_control = out_r.modem_control;

endmodule
`default_nettype wire
